// File: rtl/core/bmr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmr_pkg
// Shared constants of the block mean reducer: register width, default sizes
// and the reset value of block_size.
// ----------------------------------------------------------------------------
package bmr_pkg;

  // Width of the block_size configuration register.
  localparam int unsigned CFG_BITS = 9;

  // Defaults for the top-level parameters.
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned MAX_BLOCK_DEF   = 256;

  // Reset value of block_size.
  localparam logic [CFG_BITS-1:0] BLOCK_SIZE_RST = CFG_BITS'(1);

endpackage : bmr_pkg

// File: rtl/core/block_mean_reducer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_mean_reducer
// Piecewise aggregate approximation: averages signed samples over blocks of
// block_size samples (or up to a series end) and emits one mean per block.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake             Payload
//  --------  --------------------  ----------------------------------------
//  input     push / full           sample_i, series_end_i
//  result    empty / pop           segment_mean_o, final_segment_o
//  config    cfg_we_i              cfg_wdata_i (block_size, 9 bits)
//
//  The front end takes one sample per cycle while the job queue has room.
//  Each closed block occupies the serial divider, one quotient bit per
//  cycle; two blocks can wait in the job queue meanwhile.
//  Reset clears sum, count, queue and divider, and sets block_size to 1.
//  full rises only while the job queue is full; a waiting result does not
//  stall the divider's next job until that job is done.
// ----------------------------------------------------------------------------
module block_mean_reducer
  import bmr_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned MAX_BLOCK   = MAX_BLOCK_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [CFG_BITS-1:0]           cfg_wdata_i,
  // sample input
  input  logic                          push,
  output logic                          full,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          series_end_i,
  // segment output
  output logic                          empty,
  input  logic                          pop,
  output logic signed [SAMPLE_BITS-1:0] segment_mean_o,
  output logic                          final_segment_o
);

  // Sum must hold MAX_BLOCK full-scale samples; count must hold MAX_BLOCK.
  localparam int unsigned SUM_W = SAMPLE_BITS + $clog2(MAX_BLOCK);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int unsigned JOB_W = SUM_W + CNT_W + 1;

  logic [CFG_BITS-1:0]     block_size_q;
  logic                    in_ready;
  logic                    job_valid, job_ready;
  logic signed [SUM_W-1:0] job_sum;
  logic [CNT_W-1:0]        job_count;
  logic                    job_last;
  logic [JOB_W-1:0]        q_in_data, q_out_data;
  logic                    q_out_valid, q_out_ready;

  // Hold block_size; the user must write it only while the block is idle, the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= BLOCK_SIZE_RST;
    end else if (cfg_we_i) begin
      block_size_q <= cfg_wdata_i;
    end
  end

  assign full = !in_ready;

  // Front end: accumulate and close blocks.
  bmr_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_BLOCK   (MAX_BLOCK),
    .SUM_W       (SUM_W),
    .CNT_W       (CNT_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .block_size_i (block_size_q),
    .in_valid_i   (push),
    .in_ready_o   (in_ready),
    .sample_i     (sample_i),
    .series_end_i (series_end_i),
    .job_valid_o  (job_valid),
    .job_ready_i  (job_ready),
    .job_sum_o    (job_sum),
    .job_count_o  (job_count),
    .job_last_o   (job_last)
  );

  // Pack a closed block into one queue entry.
  assign q_in_data = {job_last, job_count, job_sum};

  bmr_queue #(
    .DATA_W (JOB_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (job_valid),
    .in_ready_o  (job_ready),
    .in_data_i   (q_in_data),
    .out_valid_o (q_out_valid),
    .out_ready_i (q_out_ready),
    .out_data_o  (q_out_data)
  );

  // Back end: divide sum by count, then present the transaction.
  bmr_divider #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W),
    .CNT_W       (CNT_W)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_out_valid),
    .job_ready_o (q_out_ready),
    .job_sum_i   (q_out_data[SUM_W-1:0]),
    .job_count_i (q_out_data[SUM_W+CNT_W-1:SUM_W]),
    .job_last_i  (q_out_data[JOB_W-1]),
    .res_empty_o (empty),
    .res_pop_i   (pop),
    .res_mean_o  (segment_mean_o),
    .res_final_o (final_segment_o)
  );

  // A series end always closes a block in the same cycle.
  a_series_end_closes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && series_end_i) |-> job_valid)
    else $error("series end did not close a block");

  // A block is handed over only with an accepted sample.
  a_job_needs_sample : assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid && job_ready |-> (push && !full))
    else $error("block queued without an accepted sample");

  // A closed block never has a zero count, so the divider never sees zero.
  a_count_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid |-> (job_count != '0))
    else $error("closed block with zero count");

endmodule : block_mean_reducer

// File: rtl/core/bmr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmr_front
// Accumulates samples into a running sum and count, and hands a closed block
// (sum, count, series end) to the job queue.
// ----------------------------------------------------------------------------
module bmr_front
  import bmr_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned MAX_BLOCK   = MAX_BLOCK_DEF,
  parameter int unsigned SUM_W       = SAMPLE_BITS + $clog2(MAX_BLOCK),
  parameter int unsigned CNT_W       = $clog2(MAX_BLOCK + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [CFG_BITS-1:0]           block_size_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          series_end_i,
  output logic                          job_valid_o,
  input  logic                          job_ready_i,
  output logic signed [SUM_W-1:0]       job_sum_o,
  output logic [CNT_W-1:0]              job_count_o,
  output logic                          job_last_o
);

  localparam int unsigned CMP_W = (CNT_W > CFG_BITS) ? CNT_W : CFG_BITS;

  logic signed [SUM_W-1:0] sum_q, sum_d, sum_next;
  logic [CNT_W-1:0]        cnt_q, cnt_d, cnt_next;
  logic [CMP_W-1:0]        bs_ext, max_ext, eff_ext;
  logic [CNT_W-1:0]        eff;
  logic                    accept, close;

  // Clamp block size: zero acts as one, anything above MAX_BLOCK as MAX_BLOCK.
  always_comb begin
    bs_ext  = CMP_W'(block_size_i);
    max_ext = CMP_W'(MAX_BLOCK);
    if (bs_ext == '0) begin
      eff_ext = CMP_W'(1);
    end else if (bs_ext > max_ext) begin
      eff_ext = max_ext;
    end else begin
      eff_ext = bs_ext;
    end
    eff = CNT_W'(eff_ext);
  end

  assign sum_next = sum_q + {{(SUM_W-SAMPLE_BITS){sample_i[SAMPLE_BITS-1]}}, sample_i};
  assign cnt_next = cnt_q + CNT_W'(1);
  assign close    = (cnt_next >= eff) || series_end_i;

  // Stall the input whenever the job queue cannot take a block.
  assign in_ready_o  = job_ready_i;
  assign accept      = in_valid_i && job_ready_i;
  assign job_valid_o = in_valid_i && close;
  assign job_sum_o   = sum_next;
  assign job_count_o = cnt_next;
  assign job_last_o  = series_end_i;

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (accept) begin
      if (close) begin
        sum_d = '0;
        cnt_d = '0;
      end else begin
        sum_d = sum_next;
        cnt_d = cnt_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

endmodule : bmr_front

// File: rtl/core/bmr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmr_queue
// Two-entry job queue between front and back end, built from a head and a
// tail register.
// ----------------------------------------------------------------------------
module bmr_queue #(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [DATA_W-1:0] in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] out_data_o
);

  logic              head_v_q, head_v_d, tail_v_q, tail_v_d;
  logic [DATA_W-1:0] head_q, head_d, tail_q, tail_d;
  logic              push, pop;

  assign in_ready_o  = !tail_v_q;
  assign out_valid_o = head_v_q;
  assign out_data_o  = head_q;
  assign push        = in_valid_i && !tail_v_q;
  assign pop         = head_v_q && out_ready_i;

  always_comb begin
    head_v_d = head_v_q;
    tail_v_d = tail_v_q;
    head_d   = head_q;
    tail_d   = tail_q;
    if (pop) begin
      if (tail_v_q) begin
        // Advance the tail; no push can happen while the tail is occupied.
        head_d   = tail_q;
        tail_v_d = 1'b0;
      end else if (push) begin
        head_d = in_data_i;
      end else begin
        head_v_d = 1'b0;
      end
    end else if (push) begin
      if (!head_v_q) begin
        head_d   = in_data_i;
        head_v_d = 1'b1;
      end else begin
        tail_d   = in_data_i;
        tail_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      tail_v_q <= 1'b0;
    end else begin
      head_v_q <= head_v_d;
      tail_v_q <= tail_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

endmodule : bmr_queue

// File: rtl/core/bmr_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmr_divider
// Back end: restoring divider, one quotient bit per cycle, on the magnitude
// of the block sum; the sign is applied at the end (truncation toward zero).
// A result register decouples the divider from the result consumer.
// ----------------------------------------------------------------------------
module bmr_divider #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned SUM_W       = 24,
  parameter int unsigned CNT_W       = 9
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  output logic                          job_ready_o,
  input  logic signed [SUM_W-1:0]       job_sum_i,
  input  logic [CNT_W-1:0]              job_count_i,
  input  logic                          job_last_i,
  output logic                          res_empty_o,
  input  logic                          res_pop_i,
  output logic signed [SAMPLE_BITS-1:0] res_mean_o,
  output logic                          res_final_o
);

  localparam int unsigned STEP_W = $clog2(SUM_W + 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W);

  logic              busy_q, busy_d, res_valid_q, res_valid_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SUM_W-1:0]  dvd_q, quot;
  logic [CNT_W-1:0]  div_q, rem_q;
  logic              neg_q, last_q;
  logic [CNT_W:0]    rem_sh, rem_diff;
  logic              ge, load, run, finish;
  logic [SAMPLE_BITS-1:0] res_mean_q;
  logic              res_final_q;

  assign load   = job_valid_i && !busy_q;
  assign run    = busy_q && (step_q != LAST_STEP);
  assign finish = busy_q && (step_q == LAST_STEP) && (!res_valid_q || res_pop_i);

  assign rem_sh   = {rem_q, dvd_q[SUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, div_q};
  assign ge       = (rem_sh >= {1'b0, div_q});
  assign quot     = neg_q ? (~dvd_q + SUM_W'(1)) : dvd_q;

  assign job_ready_o = !busy_q;
  assign res_empty_o = !res_valid_q;
  assign res_mean_o  = res_mean_q;
  assign res_final_o = res_final_q;

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (load) begin
      busy_d = 1'b1;
      step_d = '0;
    end else if (run) begin
      step_d = step_q + STEP_W'(1);
    end else if (finish) begin
      busy_d = 1'b0;
    end
    res_valid_d = res_valid_q;
    if (finish) begin
      res_valid_d = 1'b1;
    end else if (res_pop_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      neg_q  <= job_sum_i[SUM_W-1];
      dvd_q  <= job_sum_i[SUM_W-1] ? (~job_sum_i + SUM_W'(1)) : job_sum_i;
      div_q  <= job_count_i;
      rem_q  <= '0;
      last_q <= job_last_i;
    end else if (run) begin
      dvd_q <= {dvd_q[SUM_W-2:0], ge};
      rem_q <= ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
    if (finish) begin
      res_mean_q  <= quot[SAMPLE_BITS-1:0];
      res_final_q <= last_q;
    end
  end

endmodule : bmr_divider

// File: tb/tb_block_mean_reducer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_block_mean_reducer
// Self-checking bench for the block mean reducer. Samples and series-end flags
// are pushed into the block while a local model accumulates the same blocks
// and queues the segment means it should emit. Every popped segment is
// compared field by field against the oldest queued mean. The run covers the
// reset block size, directed corner cases, the largest blocks, a long output
// stall, and random series under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_block_mean_reducer;
  import bmr_pkg::*;

  localparam int SAMPLE_W     = SAMPLE_BITS_DEF;
  localparam int SETTLE_CYCLES = 40;      // margin for the divider plus the job queue
  localparam int CYCLE_LIMIT   = 600000;
  localparam int PHASE_ITEMS   = 30;

  typedef struct packed {
    logic [SAMPLE_W-1:0] mean;
    logic                closes_series;
  } segment_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                       cfg_we_i     = 1'b0;
  logic [CFG_BITS-1:0]        cfg_wdata_i  = '0;
  logic                       push         = 1'b0;
  logic                       full;
  logic signed [SAMPLE_W-1:0] sample_i     = '0;
  logic                       series_end_i = 1'b0;
  logic                       empty;
  logic                       pop          = 1'b0;
  logic signed [SAMPLE_W-1:0] segment_mean_o;
  logic                       final_segment_o;

  // Local copy of the block state and its register.
  int                  block_sum   = 0;
  int                  block_count = 0;
  logic [CFG_BITS-1:0] block_size_reg = BLOCK_SIZE_RST;

  segment_t segment_q[$];

  int error_count   = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int pop_hold_left = 0;

  block_mean_reducer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .push            (push),
    .full            (full),
    .sample_i        (sample_i),
    .series_end_i    (series_end_i),
    .empty           (empty),
    .pop             (pop),
    .segment_mean_o  (segment_mean_o),
    .final_segment_o (final_segment_o)
  );

  always #5 clk_i = ~clk_i;

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Drive pop: hold it low for a requested stretch, otherwise stall at random.
  always @(posedge clk_i) begin
    if (pop_hold_left > 0) begin
      pop_hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // Compare each popped segment with the oldest pending mean.
  always @(posedge clk_i) begin : check_segment
    segment_t want;
    if (rst_ni && pop && !empty) begin
      if (segment_q.size() == 0) begin
        $error("unexpected segment: segment_mean=%0d final_segment=%0b",
               segment_mean_o, final_segment_o);
        error_count++;
      end else begin
        want = segment_q.pop_front();
        if (segment_mean_o !== want.mean) begin
          $error("segment_mean: expected %0d, got %0d",
                 $signed(want.mean), segment_mean_o);
          error_count++;
        end
        if (final_segment_o !== want.closes_series) begin
          $error("final_segment: expected %0b, got %0b",
                 want.closes_series, final_segment_o);
          error_count++;
        end
      end
    end
  end

  function automatic int effective_block();
    if (block_size_reg == 0) return 1;
    if (block_size_reg > MAX_BLOCK_DEF) return MAX_BLOCK_DEF;
    return int'(block_size_reg);
  endfunction

  // Add one accepted sample; close the block when full or at a series end.
  task automatic accumulate_sample(input logic signed [SAMPLE_W-1:0] value,
                                   input logic last);
    segment_t seg;
    int       mean;
    block_sum   += int'(value);
    block_count += 1;
    if (block_count >= effective_block() || last) begin
      mean              = block_sum / block_count;  // truncates toward zero
      seg.mean          = SAMPLE_W'(mean);
      seg.closes_series = last;
      segment_q.insert(segment_q.size(), seg);
      block_sum   = 0;
      block_count = 0;
    end
  endtask

  // Offer one sample after a random gap and hold it until accepted. Leave push
  // high so a back-to-back sample needs no second assignment in the same step.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value,
                             input logic last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 60) gap++;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push         <= 1'b1;
    sample_i     <= value;
    series_end_i <= last;
    do @(posedge clk_i); while (full);
    accumulate_sample(value, last);
  endtask

  // Stop sending and wait for every pending segment; always wait on a clock
  // edge first so back-to-back calls never assign push twice in one step.
  task automatic drain_segments();
    push <= 1'b0;
    do @(posedge clk_i); while (segment_q.size() != 0);
  endtask

  // Write block_size only once the block has gone quiet.
  task automatic program_block_size(input logic [CFG_BITS-1:0] value);
    drain_segments();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    block_size_reg  = value;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(7))
      0:       return {1'b0, {(SAMPLE_W-1){1'b1}}};
      1:       return {1'b1, {(SAMPLE_W-1){1'b0}}};
      2:       return SAMPLE_W'($signed($urandom_range(8)) - 4);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_BITS-1:0] random_block_size();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return CFG_BITS'(MAX_BLOCK_DEF);
      3:       return CFG_BITS'($urandom_range(2 ** CFG_BITS - 1, MAX_BLOCK_DEF + 1));
      4:       return CFG_BITS'($urandom_range(40, 9));
      default: return CFG_BITS'($urandom_range(8, 1));
    endcase
  endfunction

  // Block size 1 out of reset: every sample is its own segment.
  task automatic test_reset_block_size();
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(-16'sd1, 1'b1);
    send_sample(16'sd0, 1'b0);
  endtask

  task automatic test_corner_cases();
    // Zero block size acts as one.
    program_block_size('0);
    send_sample(16'sd5, 1'b0);
    send_sample(-16'sd7, 1'b1);
    // Short final block averages over what it holds; negative means truncate up.
    program_block_size(CFG_BITS'(3));
    send_sample(-16'sd1, 1'b0);
    send_sample(-16'sd2, 1'b1);
    send_sample(16'sd7, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b0);
    // Series end on a full block gives one final segment.
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd1, 1'b1);
    // Lower the size with a block half full: it closes on the next sample.
    program_block_size(CFG_BITS'(5));
    send_sample(-16'sd9, 1'b0);
    send_sample(16'sd3, 1'b0);
    send_sample(-16'sd4, 1'b0);
    program_block_size(CFG_BITS'(2));
    send_sample(16'sd1, 1'b0);
  endtask

  // Oversized setting clamps to the largest block; drive the sum to the
  // negative rail, then close a short positive block at a series end.
  task automatic test_largest_blocks();
    program_block_size('1);
    repeat (MAX_BLOCK_DEF) send_sample(16'sh8000, 1'b0);
    repeat (MAX_BLOCK_DEF / 4 - 1) send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b1);
  endtask

  // Block the output long enough that the job queue fills and full rises.
  task automatic test_output_stall();
    program_block_size(CFG_BITS'(1));
    @(negedge clk_i);
    pop_hold_left = 300;
    @(posedge clk_i);
    repeat (20) send_sample(random_sample(), 1'($urandom_range(1)));
    drain_segments();
  endtask

  // Random series, mostly well formed, with a reprogram once 15 or more items have gone by.
  task automatic run_random_phase(input int idle_pct, input int stall_pct);
    int sent;
    int since_cfg;
    int len;
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    sent          = 0;
    since_cfg     = 0;
    program_block_size(random_block_size());
    while (sent < PHASE_ITEMS) begin
      if ($urandom_range(9) < 8) begin
        len = $urandom_range(3 * effective_block() + 2, 1);
        if (len > 40) len = $urandom_range(40, 1);
        for (int i = 0; i < len; i++) send_sample(random_sample(), i == len - 1);
      end else begin
        len = $urandom_range(12, 1);
        for (int i = 0; i < len; i++) send_sample(random_sample(), 1'($urandom_range(1)));
      end
      sent      += len;
      since_cfg += len;
      if (since_cfg >= 15) begin
        program_block_size(random_block_size());
        since_cfg = 0;
      end
    end
    drain_segments();
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, 0);
    run_random_phase(81, 0);
    run_random_phase(0, 81);
    run_random_phase(14, 14);
    send_idle_pct = 0;
    pop_stall_pct = 0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_block_size();
    test_corner_cases();
    test_largest_blocks();
    test_output_stall();
    test_random_traffic();

    drain_segments();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0 && segment_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/bmr_pkg.sv
rtl/core/bmr_front.sv
rtl/core/bmr_queue.sv
rtl/core/bmr_divider.sv
rtl/core/block_mean_reducer.sv
tb/tb_block_mean_reducer.sv
